FILE: rtl/cagc_pkg.sv
// Package for the complex AGC core: sample width, register codes, reset values,
// transaction structs and the sequencer state type.
// No dependencies.
package cagc_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 23;
	localparam int RATE_W     = 16;
	localparam int REF_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REF_LEVEL    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAXIMUM_GAIN = 3'd4;

	localparam logic [RATE_W-1:0] RST_ATTACK_RATE  = 16'd6554;
	localparam logic [RATE_W-1:0] RST_DECAY_RATE   = 16'd66;
	localparam logic [REF_W-1:0]  RST_REF_LEVEL    = 16'd4096;
	localparam logic [GAIN_W-1:0] RST_INITIAL_GAIN = 23'd65536;
	localparam logic [GAIN_W-1:0] RST_MAXIMUM_GAIN = 23'd6553600;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 23'd65536;
	localparam logic [GAIN_W-1:0] GAIN_FLOOR = 23'd7;
	localparam int                SIL_DIV    = 1000;
	localparam int                SIL_HALF   = 500;
	localparam int                OUT_LIMIT  = 16384;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] in_i;
		logic signed [SAMPLE_W-1:0] in_q;
	} cagc_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] out_i;
		logic signed [SAMPLE_W-1:0] out_q;
	} cagc_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIL_GO,
		ST_SIL_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_ERR_GO,
		ST_ERR_WAIT,
		ST_DONE
	} cagc_state_t;

endpackage

FILE: rtl/causal_complex_agc_core.sv
// Top level of the feedback complex AGC: config registers, gain state and the
// sequencer driving the serial multipliers, square root and dividers.
// Depends on cagc_pkg, cagc_mul, cagc_div, cagc_sqrt.
//
// Usage:
//   in channel  (in_valid/in_ready, in_data): one I/Q sample per transaction.
//   out channel (out_valid/out_ready, out_data): one gain-adjusted sample.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no sample is in flight. Writing the
//   initial gain also reloads the running gain.
// Flow: one sample in flight at a time; in_ready returns in the same cycle
//   as out_valid rises for its result, so the next sample can be taken then.
//   Each sample runs through the serial units in turn: two multiplier passes
//   (product, square), the 25-step root, then the error multiply, in parallel
//   with the 27-step output dividers when the output is limited to 2.0; a zero
//   sample uses only one divider, to drift the gain toward 1.0.
// Reset: registers take their default values and the gain is 1.0.
// Stall: a result waits in the output register; the next sample is accepted
//   and processed meanwhile, and its result waits until the register frees.
module causal_complex_agc_core
	import cagc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  cagc_in_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output cagc_out_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int W   = SAMPLE_W;
	localparam int GW  = GAIN_W;
	localparam int LW  = GW + 2;
	localparam int BW  = (W > LW) ? W : LW;
	localparam int MPW = LW + BW;
	localparam int PW  = W + GW;
	localparam int OW  = PW - 13;
	localparam int SW  = 2 * LW;
	localparam int MW  = LW;
	localparam int EW  = MW + 2;
	localparam int DPW = LW + RATE_W;
	localparam int DDW = DPW - 13;
	localparam int NGW = DDW + 2;
	localparam int QW  = OW + 1;
	localparam int NW  = OW + 15;

	cagc_state_t state_q, state_d;

	logic [RATE_W-1:0] attack_q, decay_q;
	logic [REF_W-1:0]  ref_q;
	logic [GW-1:0]     max_gain_q, gain_q;

	logic              xi_neg_q, xq_neg_q;
	logic [W-1:0]      xi_mag_q, xq_mag_q;
	logic [LW-1:0]     loop_i_q, loop_q_q;
	logic [OW-1:0]     outm_i_q, outm_q_q;
	logic [SW-1:0]     sum_q;
	logic              err_neg_q, big_q;
	cagc_out_t         res_q, out_data_q;
	logic              out_valid_q;

	logic              mi_start, mq_start, rt_start, di_start, dq_start;
	logic              mi_busy, mq_busy, rt_busy, di_busy, dq_busy;
	logic [LW-1:0]     mi_a, mq_a;
	logic [BW-1:0]     mi_b, mq_b;
	logic [MPW-1:0]    mi_prod, mq_prod;
	logic [MW-1:0]     root;
	logic [NW-1:0]     di_num, dq_num;
	logic [MW-1:0]     di_den;
	logic [QW-1:0]     di_quot, dq_quot;

	logic              in_acc, silent, out_free;
	logic [PW:0]       lr_i, lr_q, or_i, or_q;
	logic [EW-1:0]     err;
	logic signed [EW+3:0] errx, err10;
	logic              err_over, big;
	logic [LW-1:0]     err_mag;
	logic [RATE_W-1:0] rate;
	logic              gap_neg;
	logic [GW-1:0]     gap_mag;
	logic [GW:0]       sil_gain;
	logic [GW-1:0]     sil_gain_c;
	logic [DPW-1:0]    dr;
	logic [DDW-1:0]    dstep;
	logic [NGW-1:0]    ng, ng_fl;
	logic [GW-1:0]     loop_gain_c;
	logic [QW-1:0]     mag_i, mag_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
		return x[W-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic [W-1:0] sat(input logic neg, input logic [QW-1:0] mag);
		logic [QW-1:0] lim_p, lim_n;
		lim_p = QW'({(W-1){1'b1}});
		lim_n = QW'({1'b1, {(W-1){1'b0}}});
		if (!neg) begin
			return (mag > lim_p) ? lim_p[W-1:0] : mag[W-1:0];
		end else begin
			return (mag > lim_n) ? lim_n[W-1:0] : (~mag[W-1:0] + 1'b1);
		end
	endfunction

	cagc_mul #(.A_W(LW), .B_W(BW)) u_mul_i (
		.clk(clk), .arst_n(arst_n), .start(mi_start), .a(mi_a), .b(mi_b),
		.busy(mi_busy), .prod(mi_prod)
	);

	cagc_mul #(.A_W(LW), .B_W(BW)) u_mul_q (
		.clk(clk), .arst_n(arst_n), .start(mq_start), .a(mq_a), .b(mq_b),
		.busy(mq_busy), .prod(mq_prod)
	);

	cagc_sqrt #(.IN_W(SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(rt_start), .radicand(sum_q),
		.busy(rt_busy), .root(root)
	);

	cagc_div #(.N_W(NW), .D_W(MW), .Q_W(QW)) u_div_i (
		.clk(clk), .arst_n(arst_n), .start(di_start), .num(di_num), .den(di_den),
		.busy(di_busy), .quot(di_quot)
	);

	cagc_div #(.N_W(NW), .D_W(MW), .Q_W(QW)) u_div_q (
		.clk(clk), .arst_n(arst_n), .start(dq_start), .num(dq_num), .den(root),
		.busy(dq_busy), .quot(dq_quot)
	);

	assign in_acc   = in_valid && in_ready;
	assign silent   = (in_data.in_i == '0) && (in_data.in_q == '0);
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// rounding of the raw products
	assign lr_i = {1'b0, mi_prod[PW-1:0]} + (PW+1)'(2**(W-3));
	assign lr_q = {1'b0, mq_prod[PW-1:0]} + (PW+1)'(2**(W-3));
	assign or_i = {1'b0, mi_prod[PW-1:0]} + (PW+1)'(2**13);
	assign or_q = {1'b0, mq_prod[PW-1:0]} + (PW+1)'(2**13);

	// loop error and rate select
	assign err      = {2'b00, root} - EW'({ref_q, 1'b0});
	assign errx     = {{4{err[EW-1]}}, err};
	assign err10    = (errx <<< 3) + (errx <<< 1);
	assign err_over = (err10 > $signed({{(EW+4-REF_W){1'b0}}, ref_q}));
	assign err_mag  = err[EW-1] ? LW'(~err + 1'b1) : LW'(err);
	assign rate     = err_over ? attack_q : decay_q;
	assign big      = (root > MW'(OUT_LIMIT));

	// silence drift toward unity
	assign gap_neg    = (gain_q > UNITY_GAIN);
	assign gap_mag    = gap_neg ? (gain_q - UNITY_GAIN) : (UNITY_GAIN - gain_q);
	assign sil_gain   = gap_neg ? ({1'b0, gain_q} - {1'b0, di_quot[GW-1:0]}) :
	                              ({1'b0, gain_q} + {1'b0, di_quot[GW-1:0]});
	assign sil_gain_c = (sil_gain > {1'b0, max_gain_q}) ? max_gain_q : sil_gain[GW-1:0];

	// loop gain step, floor, clamp
	assign dr          = mi_prod[DPW-1:0] + DPW'(4096);
	assign dstep       = DDW'(dr >> 13);
	assign ng          = err_neg_q ? (NGW'(gain_q) + NGW'(dstep)) :
	                                 (NGW'(gain_q) - NGW'(dstep));
	assign ng_fl       = ng[NGW-1] ? NGW'(GAIN_FLOOR) : ng;
	assign loop_gain_c = (ng_fl > NGW'(max_gain_q)) ? max_gain_q : ng_fl[GW-1:0];

	assign mag_i = big_q ? di_quot : QW'(outm_i_q);
	assign mag_q = big_q ? dq_quot : QW'(outm_q_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = silent ? ST_SIL_GO : ST_MUL_GO;
			end
			ST_SIL_GO:   state_d = ST_SIL_WAIT;
			ST_SIL_WAIT: begin
				if (!di_busy) state_d = ST_DONE;
			end
			ST_MUL_GO:   state_d = ST_MUL_WAIT;
			ST_MUL_WAIT: begin
				if (!mi_busy && !mq_busy) state_d = ST_SQ_GO;
			end
			ST_SQ_GO:    state_d = ST_SQ_WAIT;
			ST_SQ_WAIT: begin
				if (!mi_busy && !mq_busy) state_d = ST_RT_GO;
			end
			ST_RT_GO:    state_d = ST_RT_WAIT;
			ST_RT_WAIT: begin
				if (!rt_busy) state_d = ST_ERR_GO;
			end
			ST_ERR_GO:   state_d = ST_ERR_WAIT;
			ST_ERR_WAIT: begin
				if (!mi_busy && !di_busy && !dq_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		mi_start = 1'b0;
		mq_start = 1'b0;
		rt_start = 1'b0;
		di_start = 1'b0;
		dq_start = 1'b0;
		mi_a     = {2'b00, gain_q};
		mq_a     = {2'b00, gain_q};
		mi_b     = BW'(xi_mag_q);
		mq_b     = BW'(xq_mag_q);
		di_num   = NW'({outm_i_q, 14'd0}) + NW'(root >> 1);
		dq_num   = NW'({outm_q_q, 14'd0}) + NW'(root >> 1);
		di_den   = root;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SIL_GO: begin
				di_start = 1'b1;
				di_num   = NW'(gap_mag) + NW'(SIL_HALF);
				di_den   = MW'(SIL_DIV);
			end
			ST_MUL_GO: begin
				mi_start = 1'b1;
				mq_start = 1'b1;
			end
			ST_SQ_GO: begin
				mi_start = 1'b1;
				mq_start = 1'b1;
				mi_a     = loop_i_q;
				mq_a     = loop_q_q;
				mi_b     = BW'(loop_i_q);
				mq_b     = BW'(loop_q_q);
			end
			ST_RT_GO: rt_start = 1'b1;
			ST_ERR_GO: begin
				mi_start = 1'b1;
				mi_a     = err_mag;
				mi_b     = BW'(rate);
				di_start = big;
				dq_start = big;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			attack_q    <= RST_ATTACK_RATE;
			decay_q     <= RST_DECAY_RATE;
			ref_q       <= RST_REF_LEVEL;
			max_gain_q  <= RST_MAXIMUM_GAIN;
			gain_q      <= RST_INITIAL_GAIN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SIL_WAIT && !di_busy) gain_q <= sil_gain_c;
			if (state_q == ST_ERR_WAIT && state_d == ST_DONE) gain_q <= loop_gain_c;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ATTACK_RATE:  attack_q <= cfg_data[RATE_W-1:0];
					REG_DECAY_RATE:   decay_q  <= cfg_data[RATE_W-1:0];
					REG_REF_LEVEL:    ref_q    <= cfg_data[REF_W-1:0];
					REG_INITIAL_GAIN: gain_q   <= cfg_data[GW-1:0];
					REG_MAXIMUM_GAIN: max_gain_q <= cfg_data[GW-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			xi_neg_q <= in_data.in_i[W-1];
			xq_neg_q <= in_data.in_q[W-1];
			xi_mag_q <= mag_of(in_data.in_i);
			xq_mag_q <= mag_of(in_data.in_q);
		end
		if (state_q == ST_MUL_WAIT && state_d == ST_SQ_GO) begin
			loop_i_q <= LW'(lr_i >> (W-2));
			loop_q_q <= LW'(lr_q >> (W-2));
			outm_i_q <= OW'(or_i >> 14);
			outm_q_q <= OW'(or_q >> 14);
		end
		if (state_q == ST_SQ_WAIT && state_d == ST_RT_GO) begin
			sum_q <= mi_prod[SW-1:0] + mq_prod[SW-1:0];
		end
		if (state_q == ST_ERR_GO) begin
			err_neg_q <= err[EW-1];
			big_q     <= big;
		end
		if (state_q == ST_SIL_WAIT && !di_busy) begin
			res_q <= '0;
		end
		if (state_q == ST_ERR_WAIT && state_d == ST_DONE) begin
			res_q.out_i <= sat(xi_neg_q, mag_i);
			res_q.out_q <= sat(xq_neg_q, mag_q);
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= res_q;
		end
	end

endmodule

FILE: rtl/cagc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Standalone; no package needed.
module cagc_mul #(
	parameter int A_W = 25,
	parameter int B_W = 25
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] prod
);
	localparam int CNT_W = $clog2(B_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [A_W-1:0]     a_q;
	logic [A_W:0]       sum;

	assign sum  = {1'b0, acc_q[A_W+B_W-1:B_W]} + (acc_q[0] ? {1'b0, a_q} : '0);
	assign busy = (cnt_q != '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(B_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {{A_W{1'b0}}, b};
			a_q   <= a;
		end else if (busy) begin
			acc_q <= {sum, acc_q[B_W-1:1]};
		end
	end

endmodule

FILE: rtl/cagc_div.sv
// Restoring divider, one quotient bit per cycle. The caller keeps num >> Q_W
// below den, so only the low Q_W numerator bits are iterated. No package needed.
module cagc_div #(
	parameter int N_W = 41,
	parameter int D_W = 25,
	parameter int Q_W = 27
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] num,
	input  logic [D_W-1:0] den,
	output logic           busy,
	output logic [Q_W-1:0] quot
);
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   den_q;
	logic [Q_W-1:0]   nq_q;
	logic [N_W-1:0]   hi;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign hi    = num >> Q_W;
	assign trial = {rem_q, nq_q[Q_W-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};
	assign busy  = (cnt_q != '0);
	assign quot  = nq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(Q_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= hi[D_W-1:0];
			nq_q  <= num[Q_W-1:0];
			den_q <= den;
		end else if (busy) begin
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
			nq_q  <= {nq_q[Q_W-2:0], ge};
		end
	end

endmodule

FILE: rtl/cagc_sqrt.sv
// Digit-by-digit integer square root (floor), two radicand bits per cycle.
// No package needed.
module cagc_sqrt #(
	parameter int IN_W = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   radicand,
	output logic              busy,
	output logic [IN_W/2-1:0] root
);
	localparam int RT_W  = IN_W / 2;
	localparam int CNT_W = $clog2(RT_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [IN_W-1:0]  val_q;
	logic [RT_W+1:0]  rem_q;
	logic [RT_W-1:0]  root_q;
	logic [RT_W+3:0]  rem_sh;
	logic [RT_W+3:0]  trial;
	logic [RT_W+3:0]  diff;
	logic             ge;

	assign rem_sh = {rem_q, val_q[IN_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign diff   = rem_sh - trial;
	assign busy   = (cnt_q != '0);
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(RT_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			val_q  <= {val_q[IN_W-3:0], 2'b00};
			rem_q  <= ge ? diff[RT_W+1:0] : rem_sh[RT_W+1:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

endmodule

FILE: rtl/cagc_checker.sv
// Port-level checks for the complex AGC core, bound to the top level.
// Depends on cagc_pkg.
module cagc_checker
	import cagc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input cagc_out_t             out_data,
	input logic                  cfg_valid,
	input logic                  cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output transaction changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while one is in flight");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("new result without return to idle");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind causal_complex_agc_core cagc_checker u_cagc_checker (.*);

FILE: bench/tb_causal_complex_agc_core.sv
// Self-checking bench for causal_complex_agc_core: directed corner samples, register
// decode and random bursts under random handshake gaps, checked against a local gain model.
// Depends on cagc_pkg and the core RTL only.
module tb_causal_complex_agc_core
	import cagc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          OUT_SHIFT    = 14;   // Q.27 product down to Q2.13
	localparam int          STEP_SHIFT   = 13;   // Q.13 error times Q0.16 rate into Q.16 gain
	localparam int          RAND_PHASES  = 13;
	localparam int          PHASE_ITEMS  = 150;
	localparam int          SETTLE_CYCLES = 4;
	localparam int          END_SETTLE   = 120;
	localparam int unsigned GAIN_TOP     = (1 << GAIN_W) - 1;
	localparam int unsigned RATE_TOP     = (1 << RATE_W) - 1;
	localparam int unsigned REF_TOP      = (1 << REF_W) - 1;
	localparam int unsigned IDX_TOP      = (1 << CFG_IDX_W) - 1;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	cagc_in_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	cagc_out_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	logic [GAIN_W-1:0] model_gain;
	logic [RATE_W-1:0] model_attack;
	logic [RATE_W-1:0] model_decay;
	logic [REF_W-1:0]  model_ref;
	logic [GAIN_W-1:0] model_max_gain;

	cagc_out_t agc_expected_q[$];
	int        fail_count;
	bit        tx_idle;
	bit        rx_idle;

	causal_complex_agc_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// round half away from zero
	function automatic longint round_shift(longint x, int s);
		longint mag;
		mag = ((x < 0 ? -x : x) + (longint'(1) << (s - 1))) >> s;
		return x < 0 ? -mag : mag;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint mag;
		mag = ((num < 0 ? -num : num) + den / 2) / den;
		return num < 0 ? -mag : mag;
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint root;
		longint bitv;
		root = 0;
		bitv = longint'(1) << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [SAMPLE_W-1:0] clip_sample(longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) << (SAMPLE_W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[SAMPLE_W-1:0];
	endfunction

	// advances the modelled gain by one sample and returns the expected output
	function automatic cagc_out_t agc_apply_gain(cagc_in_t s);
		longint xi, xq, g, gmax, prod_i, prod_q, loop_i, loop_q;
		longint mag, err, rate, ng, oi, oq, refl;
		cagc_out_t r;
		xi   = longint'($signed(s.in_i));
		xq   = longint'($signed(s.in_q));
		g    = longint'(model_gain);
		gmax = longint'(model_max_gain);
		refl = longint'(model_ref);
		if (xi == 0 && xq == 0) begin
			g += round_div(longint'(UNITY_GAIN) - g, SIL_DIV);
			if (g > gmax)
				g = gmax;
			model_gain = GAIN_W'(g);
			r = '0;
			return r;
		end
		prod_i = xi * g;
		prod_q = xq * g;
		loop_i = round_shift(prod_i, SAMPLE_W - 2);
		loop_q = round_shift(prod_q, SAMPLE_W - 2);
		mag    = floor_sqrt(loop_i * loop_i + loop_q * loop_q);
		err    = mag - 2 * refl;                  // reference Q.12 seen as Q.13
		rate   = (10 * err > refl) ? longint'(model_attack) : longint'(model_decay);
		ng     = g - round_shift(err * rate, STEP_SHIFT);
		if (ng < 0)
			ng = longint'(GAIN_FLOOR);
		if (ng > gmax)
			ng = gmax;
		model_gain = GAIN_W'(ng);
		oi = round_shift(prod_i, OUT_SHIFT);
		oq = round_shift(prod_q, OUT_SHIFT);
		if (mag > OUT_LIMIT) begin
			oi = round_div(oi * OUT_LIMIT, mag);
			oq = round_div(oq * OUT_LIMIT, mag);
		end
		r.out_i = clip_sample(oi);
		r.out_q = clip_sample(oq);
		return r;
	endfunction

	function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 3))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// 16-bit register value with random junk in the unused upper data bits
	function automatic logic [CFG_DATA_W-1:0] with_junk(int unsigned val);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		return {junk[CFG_DATA_W-1:RATE_W], val[RATE_W-1:0]};
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ATTACK_RATE:  model_attack   = data[RATE_W-1:0];
			REG_DECAY_RATE:   model_decay    = data[RATE_W-1:0];
			REG_REF_LEVEL:    model_ref      = data[REF_W-1:0];
			REG_INITIAL_GAIN: model_gain     = data[GAIN_W-1:0];
			REG_MAXIMUM_GAIN: model_max_gain = data[GAIN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// valid is left high after the transaction; the next call or the drain decides
	task automatic send_sample(input cagc_in_t s);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
		agc_expected_q.push_back(agc_apply_gain(s));
	endtask

	task automatic send_iq(input int i, input int q);
		cagc_in_t s;
		s.in_i = SAMPLE_W'(i);
		s.in_q = SAMPLE_W'(q);
		send_sample(s);
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (agc_expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_defaults();
		write_reg(REG_ATTACK_RATE, CFG_DATA_W'(RST_ATTACK_RATE));
		write_reg(REG_DECAY_RATE, CFG_DATA_W'(RST_DECAY_RATE));
		write_reg(REG_REF_LEVEL, CFG_DATA_W'(RST_REF_LEVEL));
		write_reg(REG_MAXIMUM_GAIN, RST_MAXIMUM_GAIN);
		write_reg(REG_INITIAL_GAIN, RST_INITIAL_GAIN);
	endtask

	// reset values: silence, full-scale overload down to the gain floor, tiny samples
	task automatic test_reset_defaults();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_iq(0, 0);
		send_iq(1, 0);
		send_iq(0, -1);
		send_iq(32767, 32767);
		send_iq(-32768, -32768);
		send_iq(-32768, 32767);
		send_iq(0, 0);
		send_iq(2048, 0);
		send_iq(0, -2048);
		wait_all_results();
	endtask

	// maximum below the floor, zero gain, register extremes
	task automatic test_gain_limits();
		write_reg(REG_MAXIMUM_GAIN, CFG_DATA_W'(3));
		write_reg(REG_INITIAL_GAIN, CFG_DATA_W'(GAIN_TOP));
		send_iq(0, 0);
		send_iq(32767, -32768);
		send_iq(100, -100);
		wait_all_results();
		write_reg(REG_MAXIMUM_GAIN, CFG_DATA_W'(GAIN_TOP));
		write_reg(REG_INITIAL_GAIN, CFG_DATA_W'(0));
		write_reg(REG_DECAY_RATE, CFG_DATA_W'(RATE_TOP));
		write_reg(REG_REF_LEVEL, CFG_DATA_W'(REF_TOP));
		send_iq(1, 1);
		send_iq(32767, 0);
		send_iq(-32768, 0);
		send_iq(0, 32767);
		wait_all_results();
		write_reg(REG_ATTACK_RATE, CFG_DATA_W'(0));
		write_reg(REG_DECAY_RATE, CFG_DATA_W'(0));
		write_reg(REG_REF_LEVEL, CFG_DATA_W'(1));
		write_reg(REG_INITIAL_GAIN, CFG_DATA_W'(GAIN_TOP));
		send_iq(32767, 32767);
		send_iq(-1, -1);
		send_iq(0, 0);
		send_iq(16384, -16384);
		wait_all_results();
	endtask

	// unmapped indexes must not disturb anything
	task automatic test_register_decode();
		for (int idx = int'(REG_MAXIMUM_GAIN) + 1; idx <= int'(IDX_TOP); idx++)
			write_reg(CFG_IDX_W'(idx), '1);
		send_iq(-2, 3);
		send_iq(-32768, 1);
		wait_all_results();
		write_defaults();
	endtask

	task automatic test_random_traffic();
		int unsigned level, burst, pick, mag_i, mag_q, sh;
		bit          tame;
		cagc_in_t    s;
		burst = 0;
		level = 1;
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph != 0) begin
				tame = $urandom_range(0, 2) == 0;
				if (tame) begin
					write_reg(REG_ATTACK_RATE, with_junk($urandom_range(1000, 20000)));
					write_reg(REG_DECAY_RATE, with_junk($urandom_range(10, 500)));
					write_reg(REG_REF_LEVEL, with_junk($urandom_range(1024, 16384)));
					write_reg(REG_MAXIMUM_GAIN, RST_MAXIMUM_GAIN);
					write_reg(REG_INITIAL_GAIN, CFG_DATA_W'($urandom_range(16384, 262144)));
				end else begin
					write_reg(REG_ATTACK_RATE, with_junk(pick_field(0, RATE_TOP)));
					write_reg(REG_DECAY_RATE, with_junk(pick_field(0, RATE_TOP)));
					write_reg(REG_REF_LEVEL, with_junk(pick_field(1, REF_TOP)));
					write_reg(REG_MAXIMUM_GAIN, CFG_DATA_W'(pick_field(0, GAIN_TOP)));
					write_reg(REG_INITIAL_GAIN, CFG_DATA_W'(pick_field(0, GAIN_TOP)));
				end
				if ($urandom_range(0, 1))
					write_reg(CFG_IDX_W'($urandom_range(int'(REG_MAXIMUM_GAIN) + 1, IDX_TOP)),
						CFG_DATA_W'($urandom));
			end
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst == 0) begin
					burst = $urandom_range(5, 40);
					sh    = $urandom_range(0, SAMPLE_W - 2);
					level = (1 << sh) + $urandom_range(0, (1 << sh) - 1);
				end
				burst--;
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					s = '0;
				end else if (pick < 25) begin
					s = cagc_in_t'($urandom);
				end else begin
					mag_i  = (pick < 30) ? 0 : $urandom_range(0, level);
					mag_q  = (pick >= 30 && pick < 35) ? 0 : $urandom_range(0, level);
					s.in_i = $urandom_range(0, 1) ? -SAMPLE_W'(mag_i) : SAMPLE_W'(mag_i);
					s.in_q = $urandom_range(0, 1) ? -SAMPLE_W'(mag_q) : SAMPLE_W'(mag_q);
				end
				send_sample(s);
				if (ph % 2 == 1 && n == PHASE_ITEMS / 2)
					wait_all_results();
			end
			wait_all_results();
		end
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin : rx_stall
			int unsigned stall;
			@(negedge clk);
			stall = rx_idle ? $urandom_range(0, 9) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_output
		cagc_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (agc_expected_q.size() == 0) begin
				$display("%0t: unexpected output transaction i=%0d q=%0d", $time,
					$signed(out_data.out_i), $signed(out_data.out_q));
				fail_count++;
			end else begin
				want = agc_expected_q.pop_front();
				if (out_data.out_i !== want.out_i) begin
					$display("%0t: out_i mismatch expected %0d actual %0d", $time,
						$signed(want.out_i), $signed(out_data.out_i));
					fail_count++;
				end
				if (out_data.out_q !== want.out_q) begin
					$display("%0t: out_q mismatch expected %0d actual %0d", $time,
						$signed(want.out_q), $signed(out_data.out_q));
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		fail_count     = 0;
		tx_idle        = 1'b0;
		rx_idle        = 1'b0;
		model_attack   = RST_ATTACK_RATE;
		model_decay    = RST_DECAY_RATE;
		model_ref      = RST_REF_LEVEL;
		model_max_gain = RST_MAXIMUM_GAIN;
		model_gain     = RST_INITIAL_GAIN;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_gain_limits();
		test_register_decode();
		test_random_traffic();

		wait_all_results();
		repeat (END_SETTLE) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/cagc_pkg.sv
rtl/cagc_mul.sv
rtl/cagc_div.sv
rtl/cagc_sqrt.sv
rtl/causal_complex_agc_core.sv
rtl/cagc_checker.sv
bench/tb_causal_complex_agc_core.sv
